// ===== design/bis_pkg.sv =====
// ----------------------------------------------------------------------------
// bis_pkg
// Shared types and constants for the body injection scanner: verdict codes,
// counter widths and the table of folded SQL injection patterns.
// ----------------------------------------------------------------------------
package bis_pkg;

    localparam int LONGEST_PATTERN_DEF = 14;
    localparam int PAT_COUNT           = 12;
    localparam int PAT_MAX_LEN         = 14;
    localparam int PAT_LEN_W           = 5;
    localparam int COUNT_W             = 33;
    localparam int MAX_SIZE_W          = 32;
    localparam logic [MAX_SIZE_W-1:0] MAX_SIZE_RESET = 32'd1048576;

    typedef enum logic [1:0] {
        VERDICT_OK        = 2'd0,
        VERDICT_TOO_LARGE = 2'd1,
        VERDICT_ZERO_BYTE = 2'd2,
        VERDICT_SQL       = 2'd3
    } verdict_t;

    // Each pattern is right aligned: the lowest byte is its final character.
    localparam logic [8*PAT_MAX_LEN-1:0] PAT_TEXT [PAT_COUNT] = '{
        "' or '1'='1",
        "' or 1=1",
        "'; drop table",
        "'; delete from",
        "union select",
        "' union select",
        "--",
        "/*",
        "*/",
        "xp_\143mdshell",
        "exec(",
        "execute("
    };

    localparam logic [PAT_LEN_W-1:0] PAT_LEN [PAT_COUNT] = '{
        5'd11, 5'd8, 5'd13, 5'd14, 5'd12, 5'd14, 5'd2, 5'd2, 5'd2, 5'd11, 5'd5, 5'd8
    };

endpackage

// ===== design/bis_cell.sv =====
// ----------------------------------------------------------------------------
// bis_cell
// One byte cell of the history window. It takes its neighbor's byte on a
// shift and returns to zero when a body ends.
// ----------------------------------------------------------------------------
module bis_cell (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       shift_en,
    input  logic       clear,
    input  logic [7:0] d_in,
    output logic [7:0] q
);

    logic [7:0] byte_reg;
    logic [7:0] byte_next;

    always_comb begin
        byte_next = byte_reg;
        if (clear) begin
            byte_next = 8'd0;
        end else if (shift_en) begin
            byte_next = d_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            byte_reg <= 8'd0;
        end else begin
            byte_reg <= byte_next;
        end
    end

    assign q = byte_reg;

endmodule

// ===== design/bis_match.sv =====
// ----------------------------------------------------------------------------
// bis_match
// Compares the newest folded byte and the history window against every
// pattern and flags a pattern that ends at the newest byte.
// ----------------------------------------------------------------------------
module bis_match #(
    parameter int LONGEST_PATTERN = bis_pkg::LONGEST_PATTERN_DEF
) (
    input  logic [7:0] cur_byte,
    input  logic [7:0] window [LONGEST_PATTERN-1],
    output logic       hit
);
    import bis_pkg::*;

    localparam int CMP_LEN = (LONGEST_PATTERN < PAT_MAX_LEN) ? LONGEST_PATTERN : PAT_MAX_LEN;

    logic [7:0] recent [LONGEST_PATTERN];

    always_comb begin
        recent[0] = cur_byte;
        for (int k = 1; k < LONGEST_PATTERN; k++) begin
            recent[k] = window[k-1];
        end
    end

    always_comb begin
        logic pat_ok;
        hit = 1'b0;
        for (int p = 0; p < PAT_COUNT; p++) begin
            pat_ok = (int'(PAT_LEN[p]) <= LONGEST_PATTERN);
            for (int k = 0; k < CMP_LEN; k++) begin
                if ((k < int'(PAT_LEN[p])) && (recent[k] != PAT_TEXT[p][8*k +: 8])) begin
                    pat_ok = 1'b0;
                end
            end
            hit = hit | pat_ok;
        end
    end

endmodule

// ===== design/body_injection_scanner.sv =====
// ----------------------------------------------------------------------------
// body_injection_scanner
// Scans a request body for SQL injection patterns, zero bytes and size.
// ----------------------------------------------------------------------------
// The body arrives one byte per beat with s_tuser flagging a real byte and
// s_tlast closing the body; a body with no bytes is a single beat with
// s_tuser low and s_tlast high. A new beat is taken every cycle while the
// result register is empty or being drained, and the verdict for a body
// appears on the master side in the cycle after its last beat. The rate is set
// by one pass through the chain of window cells and the parallel pattern
// compare on the newest byte. The body size limit is written through the cfg
// channel and should only change while no body is in flight.
module body_injection_scanner #(
    parameter int LONGEST_PATTERN = bis_pkg::LONGEST_PATTERN_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic [0:0]  s_tuser,   // [0] byte_valid
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // [1:0] verdict, [34:2] body_length
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [bis_pkg::MAX_SIZE_W-1:0] cfg_data
);
    import bis_pkg::*;

    localparam int WIN_DEPTH = LONGEST_PATTERN - 1;

    function automatic logic [7:0] fold_lower(input logic [7:0] c);
        logic [7:0] r;
        r = c;
        if ((c >= 8'h41) && (c <= 8'h5a)) begin
            r = c + 8'h20;
        end
        return r;
    endfunction

    logic [MAX_SIZE_W-1:0] max_size_reg;
    logic [COUNT_W-1:0]    byte_count_reg, byte_count_next;
    logic                  zero_seen_reg, zero_seen_next;
    logic                  pat_seen_reg, pat_seen_next;
    logic                  m_valid_reg, m_valid_next;
    verdict_t              verdict_reg, verdict_next;
    logic [COUNT_W-1:0]    length_reg, length_next;

    logic                  fire_in;
    logic                  byte_in;
    logic [7:0]            folded;
    logic                  hit;
    logic [COUNT_W-1:0]    count_upd;
    logic                  zero_upd;
    logic                  pat_upd;
    logic [7:0]            window [WIN_DEPTH];
    logic [7:0]            cell_in [WIN_DEPTH];

    assign s_tready  = !m_valid_reg || m_tready;
    assign cfg_ready = 1'b1;
    assign fire_in   = s_tvalid && s_tready;
    assign byte_in   = fire_in && s_tuser[0];
    assign folded    = fold_lower(s_tdata);

    always_comb begin
        cell_in[0] = folded;
        for (int j = 1; j < WIN_DEPTH; j++) begin
            cell_in[j] = window[j-1];
        end
    end

    for (genvar g = 0; g < WIN_DEPTH; g++) begin : g_cell
        bis_cell u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .shift_en (byte_in),
            .clear    (fire_in && s_tlast),
            .d_in     (cell_in[g]),
            .q        (window[g])
        );
    end

    bis_match #(
        .LONGEST_PATTERN (LONGEST_PATTERN)
    ) u_match (
        .cur_byte (folded),
        .window   (window),
        .hit      (hit)
    );

    always_comb begin
        count_upd = byte_count_reg;
        zero_upd  = zero_seen_reg;
        pat_upd   = pat_seen_reg;
        if (byte_in) begin
            if (!byte_count_reg[COUNT_W-1]) begin
                count_upd = byte_count_reg + COUNT_W'(1);
            end
            zero_upd = zero_seen_reg || (s_tdata == 8'd0);
            pat_upd  = pat_seen_reg || hit;
        end
    end

    always_comb begin
        byte_count_next = byte_count_reg;
        zero_seen_next  = zero_seen_reg;
        pat_seen_next   = pat_seen_reg;
        m_valid_next    = m_valid_reg && !m_tready;
        verdict_next    = verdict_reg;
        length_next     = length_reg;
        if (fire_in) begin
            if (s_tlast) begin
                byte_count_next = '0;
                zero_seen_next  = 1'b0;
                pat_seen_next   = 1'b0;
                m_valid_next    = 1'b1;
                length_next     = count_upd;
                priority if (count_upd > {1'b0, max_size_reg}) begin
                    verdict_next = VERDICT_TOO_LARGE;
                end else if (zero_upd) begin
                    verdict_next = VERDICT_ZERO_BYTE;
                end else if (pat_upd) begin
                    verdict_next = VERDICT_SQL;
                end else begin
                    verdict_next = VERDICT_OK;
                end
            end else begin
                byte_count_next = count_upd;
                zero_seen_next  = zero_upd;
                pat_seen_next   = pat_upd;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_size_reg   <= MAX_SIZE_RESET;
            byte_count_reg <= '0;
            zero_seen_reg  <= 1'b0;
            pat_seen_reg   <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                max_size_reg <= cfg_data;
            end
            byte_count_reg <= byte_count_next;
            zero_seen_reg  <= zero_seen_next;
            pat_seen_reg   <= pat_seen_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        verdict_reg <= verdict_next;
        length_reg  <= length_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {5'd0, length_reg, verdict_reg};

`ifndef SYNTHESIS
    a_result_follows_last: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(s_tvalid && s_tready && s_tlast))
        else $error("Result appeared without a closing input beat.");

    a_count_saturates: assert property (@(posedge aclk) disable iff (!aresetn)
        !(byte_count_reg[COUNT_W-1] && (|byte_count_reg[COUNT_W-2:0])))
        else $error("Byte count went past its saturation value.");

    a_body_state_cleared: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && s_tlast) |=>
            (byte_count_reg == '0) && !zero_seen_reg && !pat_seen_reg)
        else $error("Per-body state was not cleared after the last beat.");

    a_too_large_consistent: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && (verdict_reg == VERDICT_TOO_LARGE)) |->
            (length_reg > {1'b0, max_size_reg}))
        else $error("Too-large verdict given for a body within the limit.");
`endif

endmodule

// ===== tb/sv/tb_body_injection_scanner.sv =====
// ----------------------------------------------------------------------------
// tb_body_injection_scanner
// Self-checking testbench for the body injection scanner. Request bodies are
// streamed in one byte per beat with random gaps and random result-side
// stalls. A behavioral scanner inside the bench folds each byte, tracks the
// byte count, zero bytes and SQL pattern hits, and predicts the verdict of
// every body. Each result beat is checked field by field against the oldest
// predicted verdict. Directed bodies cover empty bodies, ignored beats, zero
// bytes, pattern edges and size limits. Random bodies built from text, whole
// or cut-off patterns in mixed case and raw bytes then run under a series of
// size limits.
// ----------------------------------------------------------------------------
module tb_body_injection_scanner;
    import bis_pkg::*;

    localparam logic [COUNT_W-1:0] COUNT_CAP = 33'h1_0000_0000;
    localparam int WINDOW_LEN = 13;
    localparam int RANDOM_BEATS = 1300;

    typedef struct packed {
        verdict_t           verdict;
        logic [COUNT_W-1:0] length;
    } body_result_t;

    logic                  aclk;
    logic                  aresetn;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [7:0]            s_tdata;
    logic [0:0]            s_tuser;
    logic                  s_tlast;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [39:0]           m_tdata;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [MAX_SIZE_W-1:0] cfg_data;

    string sql_patterns [12] = '{
        "' or '1'='1", "' or 1=1", "'; drop table", "'; delete from",
        "union select", "' union select", "--", "/*", "*/",
        "xp_\143mdshell", "exec(", "execute("
    };

    logic [7:0]            recent_bytes [WINDOW_LEN];
    logic [COUNT_W-1:0]    byte_total;
    bit                    saw_zero;
    bit                    saw_sql;
    logic [MAX_SIZE_W-1:0] size_limit;
    body_result_t          pending_verdicts [$];
    int                    err_count = 0;
    int                    beats_sent;
    int                    rx_hold = 0;
    bit                    steady;

    body_injection_scanner uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always begin
        aclk = 1'b0;
        #10;
        aclk = 1'b1;
        #10;
    end

    function automatic int pick_gap();
        int r;
        if (steady) begin
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 55) begin
            return 0;
        end else if (r < 90) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(4, 24);
    endfunction

    function automatic logic [7:0] fold_case(logic [7:0] c);
        if (c >= "A" && c <= "Z") begin
            return c + 8'd32;
        end
        return c;
    endfunction

    task automatic report_error(string msg);
        $display("ERROR at %0t: %s", $time, msg);
        err_count++;
    endtask

    task automatic clear_body_state();
        for (int i = 0; i < WINDOW_LEN; i++) begin
            recent_bytes[i] = 8'h00;
        end
        byte_total = '0;
        saw_zero = 1'b0;
        saw_sql = 1'b0;
    endtask

    task automatic predict_beat(logic [7:0] data, bit valid, bit last);
        logic [7:0]   window [WINDOW_LEN+1];
        logic [7:0]   folded;
        body_result_t res;
        int           len;
        bit           hit;
        if (valid) begin
            folded = fold_case(data);
            if (data == 8'h00) begin
                saw_zero = 1'b1;
            end
            if (byte_total < COUNT_CAP) begin
                byte_total = byte_total + COUNT_W'(1);
            end
            for (int i = 0; i < WINDOW_LEN; i++) begin
                window[i] = recent_bytes[i];
            end
            window[WINDOW_LEN] = folded;
            // A pattern hits when it ends on the newest byte.
            for (int p = 0; p < 12; p++) begin
                len = sql_patterns[p].len();
                hit = 1'b1;
                for (int i = 0; i < len; i++) begin
                    if (window[WINDOW_LEN + 1 - len + i] != 8'(sql_patterns[p][i])) begin
                        hit = 1'b0;
                    end
                end
                if (hit) begin
                    saw_sql = 1'b1;
                end
            end
            for (int i = 0; i < WINDOW_LEN - 1; i++) begin
                recent_bytes[i] = recent_bytes[i+1];
            end
            recent_bytes[WINDOW_LEN-1] = folded;
        end
        if (last) begin
            if (byte_total > {1'b0, size_limit}) begin
                res.verdict = VERDICT_TOO_LARGE;
            end else if (saw_zero) begin
                res.verdict = VERDICT_ZERO_BYTE;
            end else if (saw_sql) begin
                res.verdict = VERDICT_SQL;
            end else begin
                res.verdict = VERDICT_OK;
            end
            res.length = byte_total;
            pending_verdicts.push_back(res);
            clear_body_state();
        end
    endtask

    task automatic send_beat(logic [7:0] data, bit valid, bit last);
        int gap;
        gap = pick_gap();
        repeat (gap) begin
            @(negedge aclk);
            s_tvalid = 1'b0;
            s_tdata = 8'($urandom);
        end
        @(negedge aclk);
        s_tvalid = 1'b1;
        s_tdata = data;
        s_tuser = valid;
        s_tlast = last;
        do @(posedge aclk); while (!s_tready);
        predict_beat(data, valid, last);
        if (valid || last) begin
            beats_sent++;
        end
    endtask

    task automatic send_text(string text, bit close);
        for (int i = 0; i < text.len(); i++) begin
            send_beat(8'(text[i]), 1'b1, close && (i == text.len() - 1));
        end
    endtask

    task automatic drain_results();
        @(negedge aclk);
        s_tvalid = 1'b0;
        while (pending_verdicts.size() != 0) begin
            @(posedge aclk);
        end
    endtask

    task automatic write_max_size(logic [MAX_SIZE_W-1:0] value);
        drain_results();
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        cfg_valid = 1'b1;
        cfg_data = value;
        do @(posedge aclk); while (!cfg_ready);
        size_limit = value;
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    task automatic send_random_body();
        logic [7:0] body [$];
        string      pat;
        byte        c;
        int         segs;
        int         kind;
        int         n;
        bit         close_empty;
        segs = $urandom_range(0, 5);
        repeat (segs) begin
            kind = $urandom_range(0, 19);
            if (kind < 6) begin
                n = $urandom_range(1, 6);
                repeat (n) body.push_back(8'($urandom_range(32, 126)));
            end else if (kind < 13) begin
                pat = sql_patterns[$urandom_range(0, 11)];
                n = (kind == 12) ? $urandom_range(1, pat.len()) : pat.len();
                for (int i = 0; i < n; i++) begin
                    c = pat[i];
                    if (c >= "a" && c <= "z" && $urandom_range(0, 1) == 1) begin
                        c = c - 8'd32;
                    end
                    body.push_back(8'(c));
                end
            end else if (kind < 18) begin
                n = $urandom_range(1, 4);
                repeat (n) body.push_back(8'($urandom));
            end else if (kind == 18) begin
                body.push_back(8'h00);
            end else begin
                n = $urandom_range(1, 5);
                repeat (n) body.push_back(8'($urandom_range(65, 90)));
            end
        end
        close_empty = (body.size() == 0) || ($urandom_range(0, 3) == 0);
        foreach (body[i]) begin
            if ($urandom_range(0, 15) == 0) begin
                send_beat(8'($urandom), 1'b0, 1'b0);
            end
            send_beat(body[i], 1'b1, !close_empty && (i == body.size() - 1));
        end
        if (close_empty) begin
            send_beat(8'($urandom), 1'b0, 1'b1);
        end
    endtask

    task automatic test_empty_and_ignored();
        send_beat(8'h00, 1'b0, 1'b1);
        send_beat(8'hFF, 1'b0, 1'b0);
        send_beat("A", 1'b1, 1'b1);
        send_beat(8'hFF, 1'b1, 1'b0);
        send_beat(8'h00, 1'b0, 1'b1);
    endtask

    task automatic test_zero_byte();
        send_beat(8'h00, 1'b1, 1'b1);
        send_text("--", 1'b0);
        send_beat(8'h00, 1'b1, 1'b1);
    endtask

    task automatic test_pattern_edges();
        send_text("--", 1'b1);
        send_beat("/", 1'b1, 1'b0);
        send_beat(8'hA5, 1'b0, 1'b0);
        send_beat("*", 1'b1, 1'b1);
        // A pattern must not match across the end of a body.
        send_text("-", 1'b1);
        send_text("-", 1'b1);
        send_text("EXEC(", 1'b1);
    endtask

    task automatic test_size_limits();
        write_max_size('0);
        send_beat(8'h00, 1'b0, 1'b1);
        send_text("a", 1'b1);
        write_max_size(32'd2);
        send_text("ab", 1'b1);
        send_beat("-", 1'b1, 1'b0);
        send_beat(8'h00, 1'b1, 1'b0);
        send_beat("-", 1'b1, 1'b1);
        write_max_size('1);
        send_text("*/", 1'b1);
    endtask

    task automatic test_random_bodies();
        int target;
        int pick;
        target = beats_sent + RANDOM_BEATS;
        while (beats_sent < target) begin
            pick = $urandom_range(0, 6);
            case (pick)
                0: begin
                    write_max_size('0);
                end
                1: begin
                    write_max_size('1);
                end
                2: begin
                    write_max_size(MAX_SIZE_RESET);
                end
                3: begin
                    write_max_size(32'($urandom));
                end
                default: begin
                    write_max_size(32'($urandom_range(1, 48)));
                end
            endcase
            steady = ($urandom_range(0, 3) == 0);
            repeat (8) send_random_body();
        end
        steady = 1'b0;
    endtask

    always @(negedge aclk) begin
        if (rx_hold > 0 && !steady) begin
            m_tready = 1'b0;
            rx_hold--;
        end else begin
            m_tready = 1'b1;
            rx_hold = pick_gap();
        end
    end

    always @(posedge aclk) begin
        body_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_verdicts.size() == 0) begin
                report_error($sformatf("result beat 0x%h with no body pending", m_tdata));
            end else begin
                want = pending_verdicts.pop_front();
                if (m_tdata[1:0] != want.verdict) begin
                    report_error($sformatf("verdict %0d, expected %0d",
                                           m_tdata[1:0], want.verdict));
                end
                if (m_tdata[34:2] != want.length) begin
                    report_error($sformatf("body_length %0d, expected %0d",
                                           m_tdata[34:2], want.length));
                end
            end
        end
    end

    initial begin
        #15_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    initial begin
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = '0;
        s_tlast = 1'b0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        steady = 1'b0;
        beats_sent = 0;
        size_limit = MAX_SIZE_RESET;
        clear_body_state();
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        test_empty_and_ignored();
        test_zero_byte();
        test_pattern_edges();
        test_size_limits();
        test_random_bodies();

        drain_results();
        repeat (10) @(posedge aclk);
        if (err_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
